// File: sv/vdpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vdpd_pkg;

    localparam int MAX_PIXELS    = 32768;
    localparam int MAX_ROW_WIDTH = 1024;

    localparam int BYTE_W        = 8;
    localparam int ROW_WIDTH_W   = 11;
    localparam int START_LEVEL_W = 8;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int LEVEL_W       = 24;
    localparam int SIZE_W        = 4;
    localparam int MAG_W         = 8;
    localparam int DIFF_W        = 10;

    // one byte plus the zero-bit completion at a final byte closes at most four codes
    localparam int MAX_CODES     = 4;
    localparam int CODE_IDX_W    = $clog2(MAX_CODES);
    localparam int CODE_CNT_W    = $clog2(MAX_CODES + 1);

    localparam int QUEUE_DEPTH   = 4;

    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int COL_CMP_W     = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
    localparam int PIX_W         = $clog2(MAX_PIXELS + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_RESET_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_LEVEL      = 2'd2;

    localparam logic [ROW_WIDTH_W-1:0]   RESET_ROW_WIDTH   = 11'd128;
    localparam logic [START_LEVEL_W-1:0] RESET_START_LEVEL = 8'd128;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [MAG_W-1:0]  mag;
    } code_t;

    // all codes closed by one byte
    typedef struct packed {
        code_t [MAX_CODES-1:0]   codes;
        logic  [CODE_CNT_W-1:0]  cnt;
        logic                    fin;
    } rec_t;

    typedef struct packed {
        logic [ROW_WIDTH_W-1:0]   row_width;
        logic                     row_reset_enable;
        logic [START_LEVEL_W-1:0] start_level;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/vlc_dpcm_pixel_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// DPCM pixel decoder for a byte-wide, MSB-first variable-length bitstream.
// Each byte is split into its size-category codes in the cycle it is taken,
// and the codes it closes (up to four, counting the zero-bit padding of a code
// left open at a final byte) go as one entry into a four-entry queue. The
// accumulator stage takes one code per cycle and puts out one pixel per cycle,
// so every code a byte closes passes through it, codes past the pixel limit
// included although they yield nothing; a final byte that closes none passes
// through it too, and any other byte that closes none costs no accumulator time.
// With the queue empty, a taken byte is registered in the queue and its first
// pixel then in the output register. A pixel held by m_ready low stalls the
// accumulator stage. Bytes are taken every cycle while the queue has room;
// up to three codes can close inside a byte. Pixels past MAX_PIXELS in a frame
// are decoded but not delivered. Registers: index 0 row_width, 1
// row_reset_enable, 2 start_level; write them only while the block is idle.
module vlc_dpcm_pixel_decoder_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [vdpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [vdpd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [vdpd_pkg::BYTE_W-1:0]           s_stream_byte,
    input  wire logic                                  s_final_byte,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [vdpd_pkg::LEVEL_W-1:0]        m_pixel_level,
    output logic                                       m_row_end,
    output logic                                       m_frame_end,
    output logic                                       m_last_of_run
);

    logic [vdpd_pkg::ROW_WIDTH_W-1:0]   row_width_reg;
    logic                               row_reset_enable_reg;
    logic [vdpd_pkg::START_LEVEL_W-1:0] start_level_reg;
    vdpd_pkg::cfg_t                     cfg;

    logic                               q_full, q_push, q_pop, q_empty;
    vdpd_pkg::rec_t                     q_wr_data, q_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg        <= vdpd_pkg::RESET_ROW_WIDTH;
            row_reset_enable_reg <= 1'b0;
            start_level_reg      <= vdpd_pkg::RESET_START_LEVEL;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vdpd_pkg::REG_ROW_WIDTH:
                    row_width_reg <= cfg_data[vdpd_pkg::ROW_WIDTH_W-1:0];
                vdpd_pkg::REG_ROW_RESET_ENABLE:
                    row_reset_enable_reg <= cfg_data[0];
                vdpd_pkg::REG_START_LEVEL:
                    start_level_reg <= cfg_data[vdpd_pkg::START_LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{row_width:        row_width_reg,
                   row_reset_enable: row_reset_enable_reg,
                   start_level:      start_level_reg};

    vdpd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .s_final_byte  (s_final_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wr_data)
    );

    vdpd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    vdpd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .head          (q_rd_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_level (m_pixel_level),
        .m_row_end     (m_row_end),
        .m_frame_end   (m_frame_end),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

// File: sv/vdpd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vdpd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [vdpd_pkg::BYTE_W-1:0]   s_stream_byte,
    input  wire logic                          s_final_byte,
    input  wire logic                          q_full,
    output logic                               q_push,
    output vdpd_pkg::rec_t                     q_data
);

    // prefix bits seen so far of the size-category code
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_0,
        PS_1,
        PS_10,
        PS_11,
        PS_111,
        PS_1111,
        PS_11111
    } prefix_t;

    prefix_t                       prefix_reg, prefix_next;
    logic [vdpd_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [vdpd_pkg::MAG_W-1:0]    mag_reg, mag_next;
    logic [vdpd_pkg::SIZE_W-1:0]   left_reg, left_next;
    logic                          accept;

    always_comb begin
        prefix_t                         p;
        logic [vdpd_pkg::SIZE_W-1:0]     sz;
        logic [vdpd_pkg::MAG_W-1:0]      mg;
        logic [vdpd_pkg::SIZE_W-1:0]     lf;
        logic [vdpd_pkg::CODE_CNT_W-1:0] n;
        logic                            b;
        logic                            start;
        logic [vdpd_pkg::SIZE_W-1:0]     start_size;
        vdpd_pkg::rec_t                  rec;

        p          = prefix_reg;
        sz         = size_reg;
        mg         = mag_reg;
        lf         = left_reg;
        n          = '0;
        rec        = '0;
        b          = 1'b0;
        start      = 1'b0;
        start_size = '0;

        for (int i = vdpd_pkg::BYTE_W - 1; i >= 0; i--) begin
            b     = s_stream_byte[i];
            start = 1'b0;
            start_size = '0;
            if (lf != '0) begin
                mg = {mg[vdpd_pkg::MAG_W-2:0], b};
                lf = lf - 4'd1;
                if (lf == '0) begin
                    rec.codes[n[vdpd_pkg::CODE_IDX_W-1:0]] = '{size: sz, mag: mg};
                    n = n + 3'd1;
                end
            end else begin
                unique case (p)
                    PS_IDLE:  p = b ? PS_1 : PS_0;
                    PS_0: begin
                        start      = 1'b1;
                        start_size = b ? 4'd2 : 4'd1;
                    end
                    PS_1:     p = b ? PS_11 : PS_10;
                    PS_10: begin
                        start      = 1'b1;
                        start_size = b ? 4'd3 : 4'd0;
                    end
                    PS_11: begin
                        if (b) begin
                            p = PS_111;
                        end else begin
                            start      = 1'b1;
                            start_size = 4'd4;
                        end
                    end
                    PS_111: begin
                        if (b) begin
                            p = PS_1111;
                        end else begin
                            start      = 1'b1;
                            start_size = 4'd5;
                        end
                    end
                    PS_1111: begin
                        if (b) begin
                            p = PS_11111;
                        end else begin
                            start      = 1'b1;
                            start_size = 4'd6;
                        end
                    end
                    PS_11111: begin
                        start      = 1'b1;
                        start_size = b ? 4'd8 : 4'd7;
                    end
                endcase
                if (start) begin
                    p = PS_IDLE;
                    if (start_size == '0) begin
                        sz = '0;
                        rec.codes[n[vdpd_pkg::CODE_IDX_W-1:0]] = '{size: '0, mag: '0};
                        n = n + 3'd1;
                    end else begin
                        sz = start_size;
                        mg = '0;
                        lf = start_size;
                    end
                end
            end
        end

        // final byte: pad an open code with zero bits, then start a fresh frame
        if (s_final_byte) begin
            if (lf != '0) begin
                rec.codes[n[vdpd_pkg::CODE_IDX_W-1:0]] = '{size: sz, mag: mg << lf};
                n = n + 3'd1;
            end else if (p != PS_IDLE) begin
                unique case (p)
                    PS_0:     start_size = 4'd1;
                    PS_11:    start_size = 4'd4;
                    PS_111:   start_size = 4'd5;
                    PS_1111:  start_size = 4'd6;
                    PS_11111: start_size = 4'd7;
                    default:  start_size = 4'd0;
                endcase
                rec.codes[n[vdpd_pkg::CODE_IDX_W-1:0]] = '{size: start_size, mag: '0};
                n = n + 3'd1;
            end
            prefix_next = PS_IDLE;
            size_next   = '0;
            mag_next    = '0;
            left_next   = '0;
        end else begin
            prefix_next = p;
            size_next   = sz;
            mag_next    = mg;
            left_next   = lf;
        end

        rec.cnt = n;
        rec.fin = s_final_byte;
        q_data  = rec;
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && ((q_data.cnt != '0) || s_final_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= PS_IDLE;
            size_reg   <= '0;
            mag_reg    <= '0;
            left_reg   <= '0;
        end else if (accept) begin
            prefix_reg <= prefix_next;
            size_reg   <= size_next;
            mag_reg    <= mag_next;
            left_reg   <= left_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/vdpd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vdpd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  vdpd_pkg::rec_t       wr_data,
    output logic                 full,
    input  wire logic            pop,
    output vdpd_pkg::rec_t       rd_data,
    output logic                 empty
);

    localparam int PTR_W = $clog2(vdpd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vdpd_pkg::QUEUE_DEPTH + 1);

    vdpd_pkg::rec_t     entries_reg [vdpd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(vdpd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/vdpd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vdpd_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  vdpd_pkg::cfg_t                             cfg,
    input  vdpd_pkg::rec_t                             head,
    input  wire logic                                  q_empty,
    output logic                                       q_pop,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [vdpd_pkg::LEVEL_W-1:0]        m_pixel_level,
    output logic                                       m_row_end,
    output logic                                       m_frame_end,
    output logic                                       m_last_of_run
);

    localparam int COL_W = vdpd_pkg::COL_W;
    localparam int CMP_W = vdpd_pkg::COL_CMP_W;
    localparam int PIX_W = vdpd_pkg::PIX_W;
    localparam int LVL_W = vdpd_pkg::LEVEL_W;

    logic [vdpd_pkg::CODE_IDX_W-1:0] idx_reg, idx_next;
    logic signed [LVL_W-1:0]         acc_reg, acc_next;
    logic [COL_W-1:0]                col_reg, col_next;
    logic [PIX_W-1:0]                pix_reg, pix_next;

    logic                            valid_reg, valid_next;
    logic signed [LVL_W-1:0]         level_reg;
    logic                            row_end_reg, frame_end_reg, last_reg;

    vdpd_pkg::code_t                 code;
    logic [vdpd_pkg::MAG_W:0]        size_mask;
    logic                            neg;
    logic signed [vdpd_pkg::DIFF_W-1:0] diff;
    logic [CMP_W-1:0]                width_eff;
    logic                            empty_rec, go, can_emit, emit, last_code, hits_max;
    logic signed [LVL_W-1:0]         base;
    logic signed [LVL_W:0]           sum;
    logic signed [LVL_W-1:0]         sat;
    logic [CMP_W-1:0]                col_inc;
    logic                            row_end;
    logic [PIX_W-1:0]                pix_inc;
    logic                            run_last;

    always_comb begin
        code      = head.codes[idx_reg];
        // low half of the range maps to negative differences
        size_mask = (9'(1) << code.size) - 9'(1);
        neg       = (code.size != '0) && (code.size <= 4'd8)
                    && !code.mag[3'(code.size - 4'd1)];
        diff      = neg ? ($signed({2'b00, code.mag}) - $signed({1'b0, size_mask}))
                        : $signed({2'b00, code.mag});

        if (cfg.row_width == '0) begin
            width_eff = CMP_W'(1);
        end else if (CMP_W'(cfg.row_width) > CMP_W'(vdpd_pkg::MAX_ROW_WIDTH)) begin
            width_eff = CMP_W'(vdpd_pkg::MAX_ROW_WIDTH);
        end else begin
            width_eff = CMP_W'(cfg.row_width);
        end

        empty_rec = (head.cnt == '0);
        go        = !q_empty && (!valid_reg || m_ready);
        can_emit  = (pix_reg < PIX_W'(vdpd_pkg::MAX_PIXELS));
        emit      = go && !empty_rec && can_emit;
        last_code = empty_rec
                    || ({1'b0, idx_reg} == head.cnt - vdpd_pkg::CODE_CNT_W'(1));

        if ((pix_reg == '0) || (cfg.row_reset_enable && (col_reg == '0))) begin
            base = LVL_W'(cfg.start_level);
        end else begin
            base = acc_reg;
        end
        sum = (LVL_W + 1)'(base) + (LVL_W + 1)'(diff);
        if (sum[LVL_W] != sum[LVL_W-1]) begin
            sat = sum[LVL_W] ? {1'b1, {(LVL_W - 1){1'b0}}} : {1'b0, {(LVL_W - 1){1'b1}}};
        end else begin
            sat = sum[LVL_W-1:0];
        end

        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        row_end  = (col_inc >= width_eff);
        pix_inc  = pix_reg + PIX_W'(1);
        hits_max = (pix_inc == PIX_W'(vdpd_pkg::MAX_PIXELS));
        // later codes of this byte are dropped once the limit is reached
        run_last = last_code || hits_max;

        acc_next = acc_reg;
        col_next = col_reg;
        pix_next = pix_reg;
        idx_next = idx_reg;
        if (go) begin
            if (emit) begin
                acc_next = sat;
                col_next = row_end ? '0 : col_inc[COL_W-1:0];
                pix_next = pix_inc;
            end
            if (last_code) begin
                idx_next = '0;
                if (head.fin) begin
                    col_next = '0;
                    pix_next = '0;
                end
            end else begin
                idx_next = idx_reg + vdpd_pkg::CODE_IDX_W'(1);
            end
        end

        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (emit) begin
            valid_next = 1'b1;
        end
    end

    assign q_pop = go && last_code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            acc_reg   <= LVL_W'(vdpd_pkg::RESET_START_LEVEL);
            col_reg   <= '0;
            pix_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            col_reg   <= col_next;
            pix_reg   <= pix_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            level_reg     <= sat;
            row_end_reg   <= row_end;
            frame_end_reg <= head.fin && run_last;
            last_reg      <= run_last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_pixel_level = level_reg;
    assign m_row_end     = row_end_reg;
    assign m_frame_end   = frame_end_reg;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire
